// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, codes and types of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned PrioBits = 8;
  localparam int unsigned OpBits   = 2;
  localparam int unsigned CntBits  = $clog2(Depth + 1);
  localparam int unsigned IdxBits  = $clog2(Depth);

  typedef enum logic [OpBits-1:0] {
    OpInsert = 2'd0,
    OpPeek   = 2'd1,
    OpRemove = 2'd2
  } op_e;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic                success;
    logic [TagBits-1:0]  tag_out;
    logic [PrioBits-1:0] priority_out;
    logic [CntBits-1:0]  entry_count;
    logic                is_full;
    logic                is_empty;
  } res_t;

endpackage

// ===== hdl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// request and result channels of the sorted priority queue
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OpBits-1:0]   operation;
  logic [PrioBits-1:0] priority_in;
  logic [TagBits-1:0]  tag_in;

  modport source (output valid, output operation, output priority_in, output tag_in,
                  input ready);
  modport sink   (input valid, input operation, input priority_in, input tag_in,
                  output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                success;
  logic [TagBits-1:0]  tag_out;
  logic [PrioBits-1:0] priority_out;
  logic [CntBits-1:0]  entry_count;
  logic                is_full;
  logic                is_empty;

  modport source (output valid, output success, output tag_out, output priority_out,
                  output entry_count, output is_full, output is_empty, input ready);
  modport sink   (input valid, input success, input tag_out, input priority_out,
                  input entry_count, input is_full, input is_empty, output ready);
endinterface

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: takes a request, runs it once the result slot is free
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        // result slot free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// sorted entry cells with parallel compare-and-shift, count and result register
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [OpBits-1:0]   operation_i,
  input  logic [PrioBits-1:0] priority_i,
  input  logic [TagBits-1:0]  tag_i,
  output res_t                res_o
);

  logic [OpBits-1:0]   op_q;
  logic [PrioBits-1:0] prio_q;
  logic [TagBits-1:0]  tag_q;

  logic [TagBits-1:0]  tags_q  [Depth];
  logic [PrioBits-1:0] prios_q [Depth];
  logic [CntBits-1:0]  count_q, count_d;
  res_t                res_q, res_d;

  logic [Depth-1:0]    ge;
  logic                full, empty, do_ins, do_rem;
  logic [IdxBits-1:0]  top_idx;

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      prio_q <= priority_i;
      tag_q  <= tag_i;
    end
  end

  assign full    = (count_q == CntBits'(Depth));
  assign empty   = (count_q == '0);
  assign do_ins  = cmd_i.exec && (op_q == OpInsert) && !full;
  assign do_rem  = cmd_i.exec && (op_q == OpRemove) && !empty;
  assign top_idx = IdxBits'(count_q - CntBits'(1));

  // occupied cells at or above the new priority move up by one
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ge[i] = (CntBits'(i) < count_q) && (prios_q[i] >= prio_q);
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic shift, place;
    if (i == 0) begin : g_first
      assign shift = 1'b0;
      assign place = (count_q == '0) || ge[0];
    end else begin : g_rest
      assign shift = ge[i-1];
      assign place = !ge[i-1] && ((CntBits'(i) == count_q) || ge[i]);
    end
    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        if (shift) begin
          tags_q[i]  <= tags_q[(i == 0) ? 0 : i-1];
          prios_q[i] <= prios_q[(i == 0) ? 0 : i-1];
        end else if (place) begin
          tags_q[i]  <= tag_q;
          prios_q[i] <= prio_q;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntBits'(1);
    end else if (do_rem) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.entry_count  = count_d;
    res_d.is_full      = (count_d == CntBits'(Depth));
    res_d.is_empty     = (count_d == '0);
    unique case (op_q)
      OpInsert: res_d.success = !full;
      OpRemove: res_d.success = !empty;
      OpPeek: begin
        if (!empty) begin
          res_d.success      = 1'b1;
          res_d.tag_out      = tags_q[top_idx];
          res_d.priority_out = prios_q[top_idx];
        end
      end
      default: res_d.success = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// priority queue of up to 16 tagged entries kept sorted by priority
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one request per transaction: operation (insert, peek, remove),
//   priority_in and tag_in. out_o returns one result per request: success,
//   the top entry on a peek, the entry count and the full and empty flags.
//   among equal priorities the entry inserted first leaves first.
// timing:
//   a request is registered in the cycle it is taken and executed once the
//   result register is free, when all cells compare against the new priority
//   and shift at once; the result is valid the cycle after that. in_i.ready is
//   high only in idle, so no request is taken until the last one has executed.
// stall:
//   a held result sits in the output register; one further request is taken
//   meanwhile and waits until out_o.ready frees the register.
// reset:
//   rst_ni empties the queue, returns the controller to idle and clears
//   out_o.valid; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  cmd_t cmd;
  res_t res;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .operation_i (in_i.operation),
    .priority_i  (in_i.priority_in),
    .tag_i       (in_i.tag_in),
    .res_o       (res)
  );

  assign out_o.success      = res.success;
  assign out_o.tag_out      = res.tag_out;
  assign out_o.priority_out = res.priority_out;
  assign out_o.entry_count  = res.entry_count;
  assign out_o.is_full      = res.is_full;
  assign out_o.is_empty     = res.is_empty;

endmodule
